FILE: sv/tvcp_pkg.sv
// Shared types, operation codes and constants for the tagged value chunk pool.
// No dependencies; used by every other file in the block.
package tvcp_pkg;

  localparam int POOL_ENTRIES_DEF = 1024;

  localparam int HANDLE_W = 16;
  localparam int NUMBER_W = 32;
  localparam int LEN_W    = 3;
  localparam int HEAD_W   = 15;

  // immediates hold a 14-bit signed value above a two-bit tag
  localparam int IMM_BITS = 14;
  localparam int LEN_LSB  = 12;

  localparam logic [HANDLE_W-1:0] TAG_INT = 16'h8001;
  localparam logic [HANDLE_W-1:0] TAG_VEC = 16'h8003;

  typedef enum logic [2:0] {
    FN_NEW_INT = 3'd0,
    FN_NEW_VEC = 3'd1,
    FN_FREE    = 3'd2,
    FN_SIZE    = 3'd3,
    FN_AS_INT  = 3'd4,
    FN_HEAD    = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // even, non-negative and indexing inside the pool
  function automatic logic handle_ok(logic [HANDLE_W-1:0] h, logic [HANDLE_W-1:0] entries);
    handle_ok = !h[0] && !h[HANDLE_W-1] && ({1'b0, h[HANDLE_W-1:1]} < entries);
  endfunction

endpackage

FILE: sv/tvcp_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Holds either the tag/link words or the data words of the pool; depends on tvcp_pkg for its defaults.
module tvcp_ram #(
  parameter int DEPTH = tvcp_pkg::POOL_ENTRIES_DEF,
  parameter int WIDTH = tvcp_pkg::HANDLE_W,
  localparam int AW   = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

FILE: sv/tagged_value_chunk_pool_unit.sv
// Tagged value chunk pool: free-list allocator over two synchronous RAMs.
// Depends on tvcp_pkg and tvcp_ram.
//
// Usage
//   Input: drive in_func, in_number, in_vec_length and in_handle_in with start
//   high; the beat is taken at a rising edge where start is high and busy low.
//   Output: one result per input beat, held on the out_ ports for exactly one
//   cycle while out_valid is high. The receiver cannot stall, so nothing waits.
//   Timing: the accepting edge issues the RAM reads; the following cycle does
//   the read-modify-write and the result registers load at its end, so
//   out_valid rises as that cycle ends and the result is taken while it is
//   high. busy stays high through that cycle, so a new beat is not taken
//   before the result registers load. The RAM read of the head chunk's link
//   ahead of its write-back is what sets this spacing of beats.
//   Reset: rst_n (synchronous, active low) puts the head at the top chunk and
//   starts a pass that rewrites every link word, one per cycle, with busy high
//   until the pass ends; only then is the first beat taken.
//   out_free_head always shows the free-list head after the operation.
module tagged_value_chunk_pool_unit #(
  parameter int POOL_ENTRIES = tvcp_pkg::POOL_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic signed [31:0] in_number,
  input  logic [2:0]  in_vec_length,
  input  logic signed [15:0] in_handle_in,
  output logic        out_valid,
  output logic signed [15:0] out_handle_out,
  output logic signed [31:0] out_int_out,
  output logic [2:0]  out_size_out,
  output logic [14:0] out_free_head
);

  localparam int AW = (POOL_ENTRIES > 2) ? $clog2(POOL_ENTRIES) : 1;
  localparam int HW = tvcp_pkg::HANDLE_W;
  localparam int NW = tvcp_pkg::NUMBER_W;
  localparam int LW = tvcp_pkg::LEN_W;
  localparam logic [HW-1:0] ENTRIES   = HW'(POOL_ENTRIES);
  localparam logic [HW-1:0] HEAD_INIT = HW'(2 * (POOL_ENTRIES - 1));
  localparam logic [AW-1:0] LAST_IDX  = AW'(POOL_ENTRIES - 1);

  tvcp_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [HW-1:0] head_r, head_nxt;

  logic [2:0]    func_r;
  logic [NW-1:0] num_r;
  logic [LW-1:0] vlen_r;
  logic [HW-1:0] hin_r;

  logic          out_valid_r, out_valid_nxt;
  logic [HW-1:0] out_handle_r, out_handle_nxt;
  logic [NW-1:0] out_int_r, out_int_nxt;
  logic [LW-1:0] out_size_r, out_size_nxt;

  logic          tag_we, data_we;
  logic [AW-1:0] tag_waddr, tag_raddr, data_waddr, data_raddr;
  logic [HW-1:0] tag_wdata, tag_q;
  logic [NW-1:0] data_wdata, data_q;

  logic          accept;
  logic          is_imm, pop_op, got_ok, hin_ok;
  logic [HW-1:0] next_link;

  tvcp_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(HW)) u_tag_ram (
    .clk     (clk),
    .we      (tag_we),
    .waddr   (tag_waddr),
    .wdata   (tag_wdata),
    .raddr   (tag_raddr),
    .rdata_r (tag_q)
  );

  tvcp_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(NW)) u_data_ram (
    .clk     (clk),
    .we      (data_we),
    .waddr   (data_waddr),
    .wdata   (data_wdata),
    .raddr   (data_raddr),
    .rdata_r (data_q)
  );

  assign busy   = (state_r != tvcp_pkg::ST_IDLE);
  assign accept = start && !busy;

  // read addresses are issued from the ports on the accepting edge
  assign tag_raddr  = ((in_func == tvcp_pkg::FN_NEW_INT) || (in_func == tvcp_pkg::FN_NEW_VEC))
                      ? head_r[AW:1] : in_handle_in[AW:1];
  assign data_raddr = in_handle_in[AW:1];

  assign is_imm = (&num_r[NW-1:tvcp_pkg::IMM_BITS-1]) || !(|num_r[NW-1:tvcp_pkg::IMM_BITS-1]);
  assign pop_op = ((func_r == tvcp_pkg::FN_NEW_INT) && !is_imm) ||
                  (func_r == tvcp_pkg::FN_NEW_VEC);
  assign got_ok = tvcp_pkg::handle_ok(head_r, ENTRIES);
  assign hin_ok = tvcp_pkg::handle_ok(hin_r, ENTRIES);
  assign next_link = got_ok ? tag_q : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tvcp_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      head_r      <= HEAD_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      num_r  <= in_number;
      vlen_r <= in_vec_length;
      hin_r  <= in_handle_in;
    end
    out_handle_r <= out_handle_nxt;
    out_int_r    <= out_int_nxt;
    out_size_r   <= out_size_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    head_nxt       = head_r;
    out_valid_nxt  = 1'b0;
    out_handle_nxt = '0;
    out_int_nxt    = '0;
    out_size_nxt   = '0;
    tag_we         = 1'b0;
    tag_waddr      = clr_cnt_r;
    tag_wdata      = '0;
    data_we        = 1'b0;
    data_waddr     = head_r[AW:1];
    data_wdata     = '0;

    unique case (state_r)
      tvcp_pkg::ST_CLEAR: begin
        // link chain: entry i points at i-1, entry 0 at itself
        tag_we      = 1'b1;
        tag_wdata   = (clr_cnt_r == '0) ? '0 : HW'({clr_cnt_r - AW'(1), 1'b0});
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_IDX) begin
          state_nxt = tvcp_pkg::ST_IDLE;
        end
      end
      tvcp_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = tvcp_pkg::ST_EXEC;
        end
      end
      tvcp_pkg::ST_EXEC: begin
        state_nxt     = tvcp_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        if (pop_op) begin
          out_handle_nxt = head_r;
          head_nxt       = tvcp_pkg::handle_ok(next_link, ENTRIES) ? next_link : '0;
          tag_waddr      = head_r[AW:1];
          data_waddr     = head_r[AW:1];
          tag_we         = got_ok;
          data_we        = got_ok;
          if (func_r == tvcp_pkg::FN_NEW_INT) begin
            tag_wdata  = tvcp_pkg::TAG_INT;
            data_wdata = num_r;
          end else begin
            tag_wdata  = tvcp_pkg::TAG_VEC | (HW'(vlen_r) << tvcp_pkg::LEN_LSB);
            data_wdata = NW'(vlen_r);
          end
        end else begin
          case (func_r)
            tvcp_pkg::FN_NEW_INT: begin
              out_handle_nxt = {num_r[tvcp_pkg::IMM_BITS-1:0], 2'b01};
            end
            tvcp_pkg::FN_FREE: begin
              if (hin_ok) begin
                tag_we    = 1'b1;
                tag_waddr = hin_r[AW:1];
                tag_wdata = head_r;
                head_nxt  = hin_r;
              end
            end
            tvcp_pkg::FN_SIZE: begin
              if (hin_ok) begin
                out_size_nxt = tag_q[tvcp_pkg::LEN_LSB +: LW];
              end
            end
            tvcp_pkg::FN_AS_INT: begin
              if (hin_r[0]) begin
                out_int_nxt = {{(NW-HW+2){hin_r[HW-1]}}, hin_r[HW-1:2]};
              end else if (hin_ok) begin
                out_int_nxt = data_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = tvcp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_handle_out = out_handle_r;
  assign out_int_out    = out_int_r;
  assign out_size_out   = out_size_r;
  assign out_free_head  = head_r[14:0];

endmodule
